### rtl/rau_pkg.sv
`default_nettype none
package rau_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int DEN_W  = OPERAND_WIDTH - 1;
    localparam int PROD_W = 2 * OPERAND_WIDTH;        // signed product width
    localparam int MAG_W  = 2 * OPERAND_WIDTH + 1;    // magnitude of sum of products
    localparam int CNT_W  = $clog2(MAG_W + 1);
    localparam int RES_NUM_W = 32;
    localparam int RES_DEN_W = 30;

    typedef enum logic [2:0] {
        FUNC_ADD = 3'd0,
        FUNC_SUB = 3'd1,
        FUNC_MUL = 3'd2,
        FUNC_DIV = 3'd3,
        FUNC_CMP = 3'd4
    } t_func;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_FORM,
        ST_GCD,
        ST_DIVN,
        ST_DIVD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic mul;
        logic form;
        logic gcd_init;
        logic gcd_step;
        logic div_init_num;
        logic div_init_den;
        logic div_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic gcd_done;
        logic div_done;
    } t_status;

endpackage
`default_nettype wire

### rtl/rau_ctrl.sv
`default_nettype none
module rau_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire logic            i_out_free,
    input  wire rau_pkg::t_status i_status,
    output rau_pkg::t_cmd        o_cmd,
    output logic                 o_busy
);
    import rau_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_start) n_state = ST_MUL;
            ST_MUL:  n_state = ST_FORM;
            ST_FORM: n_state = ST_GCD;
            ST_GCD:  if (i_status.gcd_done) n_state = ST_DIVN;
            ST_DIVN: if (i_status.div_done) n_state = ST_DIVD;
            ST_DIVD: if (i_status.div_done) n_state = ST_DONE;
            ST_DONE: if (i_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            ST_MUL:  o_cmd.mul = 1'b1;
            ST_FORM: begin
                o_cmd.form     = 1'b1;
            end
            ST_GCD: begin
                o_cmd.gcd_step     = 1'b1;
                o_cmd.div_init_num = i_status.gcd_done;
            end
            ST_DIVN: begin
                o_cmd.div_step     = 1'b1;
                o_cmd.div_init_den = i_status.div_done;
            end
            ST_DIVD: begin
                o_cmd.div_step = 1'b1;
            end
            ST_DONE: o_cmd.finish = i_out_free;
            default: o_busy = 1'b1;
        endcase
        o_cmd.gcd_init = (r_state == ST_FORM);
    end
endmodule
`default_nettype wire

### rtl/rau_dp.sv
`default_nettype none
module rau_dp (
    input  wire logic                          i_clk,
    input  wire rau_pkg::t_cmd                 i_cmd,
    input  wire logic [2:0]                    i_func,
    input  wire logic signed [rau_pkg::OPERAND_WIDTH-1:0] i_a_num,
    input  wire logic [rau_pkg::DEN_W-1:0]     i_a_den,
    input  wire logic signed [rau_pkg::OPERAND_WIDTH-1:0] i_b_num,
    input  wire logic [rau_pkg::DEN_W-1:0]     i_b_den,
    output rau_pkg::t_status                   o_status,
    output logic [rau_pkg::RES_NUM_W-1:0]      o_res_num,
    output logic [rau_pkg::RES_DEN_W-1:0]      o_res_den,
    output logic                               o_less,
    output logic                               o_equal,
    output logic                               o_div_error
);
    import rau_pkg::*;

    logic [2:0]                     r_func;
    logic signed [OPERAND_WIDTH-1:0] r_an, r_bn;
    logic [DEN_W-1:0]               r_ad, r_bd;
    logic signed [PROD_W:0]         r_lhs, r_rhs, r_nn;   // one spare bit
    logic [PROD_W-1:0]              r_dd;
    logic                           r_dneg;
    logic                           r_neg;
    logic [MAG_W-1:0]               r_mag, r_den;
    logic [MAG_W-1:0]               r_gx, r_gy;
    logic [CNT_W-1:0]               r_shift;
    logic [MAG_W-1:0]               r_q, r_rem, r_dvd;
    logic [CNT_W-1:0]               r_cnt;
    logic [MAG_W-1:0]               r_gcd;
    logic [MAG_W-1:0]               r_qnum;
    logic                           r_less, r_equal, r_err;

    logic [DEN_W-1:0] w_ad, w_bd;
    assign w_ad = (i_a_den == '0) ? DEN_W'(1) : i_a_den;
    assign w_bd = (i_b_den == '0) ? DEN_W'(1) : i_b_den;

    // Products, each on its own multiplier, registered.
    logic signed [PROD_W:0] w_sum;
    logic [MAG_W-1:0]       w_abs_n;
    logic [MAG_W-1:0]       w_gmin, w_gdiff;
    logic [MAG_W:0]         w_trial;

    always_comb begin
        priority case (r_func)
            FUNC_ADD: w_sum = r_lhs + r_rhs;
            FUNC_SUB: w_sum = r_lhs - r_rhs;
            FUNC_MUL: w_sum = r_nn;
            FUNC_DIV: w_sum = r_dneg ? -r_lhs : r_lhs;
            default:  w_sum = '0;
        endcase
        w_abs_n = (w_sum < 0) ? MAG_W'(-w_sum) : MAG_W'(w_sum);
        w_gmin  = (r_gx < r_gy) ? r_gx : r_gy;
        w_gdiff = (r_gx < r_gy) ? (r_gy - r_gx) : (r_gx - r_gy);
        w_trial = {r_rem[MAG_W-1:0], r_dvd[MAG_W-1]} - {1'b0, r_gcd};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_an   <= i_a_num;
            r_bn   <= i_b_num;
            r_ad   <= w_ad;
            r_bd   <= w_bd;
            r_err  <= 1'b0;
        end
        if (i_cmd.mul) begin
            r_lhs <= (PROD_W+1)'(PROD_W'(r_an) * PROD_W'($signed({1'b0, r_bd})));
            r_rhs <= (PROD_W+1)'(PROD_W'(r_bn) * PROD_W'($signed({1'b0, r_ad})));
            r_nn  <= (PROD_W+1)'(PROD_W'(r_an) * PROD_W'(r_bn));
            if (r_func == FUNC_DIV) begin
                r_dd   <= PROD_W'(r_ad * (r_bn < 0 ? -PROD_W'(r_bn) : PROD_W'(r_bn)));
                r_dneg <= r_bn < 0;
            end else begin
                r_dd   <= PROD_W'(r_ad) * PROD_W'(r_bd);
                r_dneg <= 1'b0;
            end
        end
        if (i_cmd.form) begin
            r_less  <= r_lhs < r_rhs;
            r_equal <= r_lhs == r_rhs;
            if (r_func == FUNC_DIV && r_bn == '0) begin
                r_err <= 1'b1;
                r_neg <= 1'b0;
                r_mag <= '0;
                r_den <= MAG_W'(1);
            end else if (r_func == FUNC_ADD || r_func == FUNC_SUB ||
                         r_func == FUNC_MUL || r_func == FUNC_DIV) begin
                r_neg <= w_sum < 0;
                r_mag <= w_abs_n;
                r_den <= MAG_W'(r_dd);
            end else begin
                r_neg <= 1'b0;
                r_mag <= '0;
                r_den <= MAG_W'(1);
            end
        end
        // Binary gcd: strip common twos, then subtract; one step a cycle.
        if (i_cmd.gcd_init) begin
            r_gx    <= (r_func == FUNC_DIV && r_bn == '0) ? '0 :
                       ((r_func == FUNC_ADD || r_func == FUNC_SUB ||
                         r_func == FUNC_MUL || r_func == FUNC_DIV) ? w_abs_n : '0);
            r_gy    <= (r_func == FUNC_DIV && r_bn == '0) ? MAG_W'(1) :
                       ((r_func == FUNC_ADD || r_func == FUNC_SUB ||
                         r_func == FUNC_MUL || r_func == FUNC_DIV) ? MAG_W'(r_dd)
                                                                  : MAG_W'(1));
            r_shift <= '0;
        end else if (i_cmd.gcd_step && !o_status.gcd_done) begin
            if (r_gx == '0) begin
                r_gx <= r_gy;
            end else if (!r_gx[0] && !r_gy[0]) begin
                r_gx    <= r_gx >> 1;
                r_gy    <= r_gy >> 1;
                r_shift <= r_shift + CNT_W'(1);
            end else if (!r_gx[0]) begin
                r_gx <= r_gx >> 1;
            end else if (!r_gy[0]) begin
                r_gy <= r_gy >> 1;
            end else begin
                r_gx <= w_gmin;
                r_gy <= w_gdiff;
            end
        end
        // Restoring divider, one quotient bit a cycle.
        if (i_cmd.div_init_num || i_cmd.div_init_den) begin
            r_gcd <= (i_cmd.div_init_num ? r_gx << r_shift : r_gcd);
            r_dvd <= i_cmd.div_init_num ? r_mag : r_den;
            r_rem <= '0;
            r_q   <= '0;
            r_cnt <= '0;
            if (i_cmd.div_init_den) r_qnum <= r_q;
        end else if (i_cmd.div_step && !o_status.div_done) begin
            if (!w_trial[MAG_W]) begin
                r_rem <= w_trial[MAG_W-1:0];
                r_q   <= {r_q[MAG_W-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[MAG_W-2:0], r_dvd[MAG_W-1]};
                r_q   <= {r_q[MAG_W-2:0], 1'b0};
            end
            r_dvd <= r_dvd << 1;
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (i_cmd.finish) begin
            r_qnum <= r_qnum;
        end
    end

    // gcd loop ends when y reaches zero with x nonzero (x holds odd part).
    assign o_status.gcd_done = (r_gy == '0) && (r_gx != '0);
    assign o_status.div_done = (r_cnt == CNT_W'(MAG_W));

    logic [MAG_W-1:0] w_num_s;
    assign w_num_s     = r_neg ? -r_qnum : r_qnum;
    assign o_res_num   = RES_NUM_W'(w_num_s);
    assign o_res_den   = RES_DEN_W'(r_q);
    assign o_less      = r_less;
    assign o_equal     = r_equal;
    assign o_div_error = r_err;
endmodule
`default_nettype wire

### rtl/rational_arithmetic_unit_core.sv
// Rational arithmetic unit.
// Input channel (s_axis): one item holds func, a_num, a_den, b_num, b_den.
// Output channel (m_axis): one item holds the reduced res_num/res_den in
// tdata and the flags less, equal and div_error in tuser.
// Each item runs through a controller and a shared datapath: the registered
// cross products (ST_MUL), the numerator form (ST_FORM), a binary gcd that
// takes one step a cycle (ST_GCD), then two restoring divisions by the gcd,
// first of the numerator (ST_DIVN), then of the denominator (ST_DIVD).
// One item is in the block at a time; s_axis_tready is high only while idle.
// The result stays on m_axis with tvalid high until it is taken; while the
// receiver stalls no new item is accepted.
// Reset (i_rst_n low, synchronous) returns the controller to idle and drops
// m_axis_tvalid; the datapath registers hold no state of meaning.
`default_nettype none
module rational_arithmetic_unit_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata, low bit up: func[2:0], a_num[18:3], a_den[33:19], b_num[49:34],
    // b_den[64:50], zero fill to 72 bits.
    input  wire logic [71:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata, low bit up: res_num[31:0], res_den[61:32], zero fill to 64 bits.
    output logic [63:0]      m_axis_tdata,
    // tuser, low bit up: less, equal, div_error.
    output logic [2:0]       m_axis_tuser
);
    import rau_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_busy;
    logic [RES_NUM_W-1:0] w_num;
    logic [RES_DEN_W-1:0] w_den;
    logic w_less, w_equal, w_err;
    logic r_done;

    assign s_axis_tready = !w_busy;

    rau_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (s_axis_tvalid),
        .i_out_free (m_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_busy     (w_busy)
    );

    rau_dp u_dp (
        .i_clk       (i_clk),
        .i_cmd       (w_cmd),
        .i_func      (s_axis_tdata[2:0]),
        .i_a_num     (s_axis_tdata[18:3]),
        .i_a_den     (s_axis_tdata[33:19]),
        .i_b_num     (s_axis_tdata[49:34]),
        .i_b_den     (s_axis_tdata[64:50]),
        .o_status    (w_status),
        .o_res_num   (w_num),
        .o_res_den   (w_den),
        .o_less      (w_less),
        .o_equal     (w_equal),
        .o_div_error (w_err)
    );

    // Result is valid once both divisions are through.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else if (w_cmd.finish) begin
            r_done <= 1'b0;
        end else if (w_cmd.div_step && w_status.div_done && !w_cmd.div_init_den) begin
            r_done <= 1'b1;
        end
    end

    assign m_axis_tvalid = r_done;
    assign m_axis_tdata  = {2'b00, w_den, w_num};
    assign m_axis_tuser  = {w_err, w_equal, w_less};
endmodule
`default_nettype wire

### rtl/rau_checker.sv
`default_nettype none
module rau_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [63:0] m_axis_tdata,
    input wire logic [2:0]  m_axis_tuser
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while result pending");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tdata[31:0] == 32'd0)
        else $error("error result not zero");
    a_den_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[61:32] != 30'd0)
        else $error("zero denominator");
endmodule

bind rational_arithmetic_unit_core rau_checker u_rau_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
